>>> hdl/cpid_pkg.sv
// Shared widths, register indexes and reset values of the clamped PID regulator.
`timescale 1ns / 1ps

package cpid_pkg;

  localparam int ERR_W      = 16;  // error sample
  localparam int GAIN_W     = 16;  // gains and step period
  localparam int LIMIT_W    = 31;  // symmetric clamp limits
  localparam int ACC_W      = 48;  // integral, signed Q32.16
  localparam int FRAC_W     = 16;  // fraction bits of the Q.16 values
  localparam int PROD_W     = 64;  // multiplier result
  localparam int TERM_W     = 49;  // clamped term
  localparam int SUM_W      = 50;  // Q.16 sum of the three terms
  localparam int OUT_W      = 32;  // correction
  localparam int DIGIT_W    = 4;   // multiplier digit, bits per cycle
  localparam int DIGITS     = GAIN_W / DIGIT_W;
  localparam int CNT_W      = $clog2(DIGITS);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef logic [CFG_IDX_W-1:0] cfg_index_t;

  localparam cfg_index_t REG_PROP_GAIN    = 3'd0;
  localparam cfg_index_t REG_INTEG_GAIN   = 3'd1;
  localparam cfg_index_t REG_DERIV_GAIN   = 3'd2;
  localparam cfg_index_t REG_STEP_PERIOD  = 3'd3;
  localparam cfg_index_t REG_PROP_LIMIT   = 3'd4;
  localparam cfg_index_t REG_INTEG_LIMIT  = 3'd5;
  localparam cfg_index_t REG_DERIV_LIMIT  = 3'd6;
  localparam cfg_index_t REG_OUTPUT_LIMIT = 3'd7;

  localparam logic [GAIN_W-1:0]  STEP_PERIOD_RST = '1;
  localparam logic [LIMIT_W-1:0] LIMIT_RST       = '1;

  // integral saturation bounds, sign extended to the sum width
  localparam logic signed [SUM_W-1:0] ACC_MAX_S =
    {{(SUM_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] ACC_MIN_S =
    {{(SUM_W-ACC_W+1){1'b1}}, {(ACC_W-1){1'b0}}};

  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (FRAC_W - 1);

endpackage

>>> hdl/clamped_pid_controller_top.sv
// Clamped PID regulator: sequencer, digit-serial multiplier, clamps and registers.
`timescale 1ns / 1ps
//
// Input stream s_axis: tdata carries the signed error sample, tuser the
// operation (0 = process sample, 1 = clear the integral). A sample item gives
// one correction on m_axis; a clear item gives none.
// Configuration: cfg_valid/cfg_ready with cfg_index selecting one of eight
// registers (gains, step period, four limits) and cfg_data; always ready,
// write only while the block holds no item in flight.
// A sample runs up to four products through one shift-and-add multiplier that
// eats the 16-bit gain four bits a cycle: each product passes through load,
// four digit steps, clamp and accumulate. The error times period update, P and
// I always run; D runs only once an earlier sample has been seen. Round and
// output steps follow the products. No new item is taken until the result is
// in the output register; the next item is taken in the cycle after that.
// The output register holds a result while m_axis_tready is low; the block
// still accepts the next item, and its result waits at the output step until
// the register is free.
// Reset (rst, synchronous) restores the register defaults, clears the
// integral, the previous error and the first-sample flag, and drops m_axis.

module clamped_pid_controller_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [cpid_pkg::ERR_W-1:0]         s_axis_tdata,  // [15:0] error_sample
  input  logic                               s_axis_tuser,  // [0] operation
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [cpid_pkg::OUT_W-1:0]         m_axis_tdata,  // [31:0] correction
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  cpid_pkg::cfg_index_t               cfg_index,
  input  logic [cpid_pkg::CFG_DATA_W-1:0]    cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_MUL, S_TERM, S_ACC, S_ROUND, S_OUT
  } state_t;

  typedef enum logic [1:0] {
    PH_INT, PH_P, PH_I, PH_D
  } phase_t;

  state_t state;
  phase_t phase;

  logic [cpid_pkg::GAIN_W-1:0]  prop_gain, integ_gain, deriv_gain, step_period;
  logic [cpid_pkg::LIMIT_W-1:0] prop_limit, integ_limit, deriv_limit, output_limit;

  logic signed [cpid_pkg::ACC_W-1:0]  integ;
  logic signed [cpid_pkg::ERR_W-1:0]  prev_err;
  logic                               have_prev;
  logic signed [cpid_pkg::ERR_W-1:0]  err;

  logic signed [cpid_pkg::ACC_W-1:0]  mul_a;
  logic [cpid_pkg::GAIN_W-1:0]        mul_b;
  logic [cpid_pkg::CNT_W-1:0]         dcnt;
  logic signed [cpid_pkg::PROD_W-1:0] prod;
  logic signed [cpid_pkg::TERM_W-1:0] term;
  logic signed [cpid_pkg::SUM_W-1:0]  sum;
  logic [cpid_pkg::OUT_W-1:0]         out_data;
  logic                               out_valid;

  logic                                             s_fire;
  logic [cpid_pkg::DIGIT_W-1:0]                     digit;
  logic signed [cpid_pkg::ACC_W+cpid_pkg::DIGIT_W:0] pp;
  logic signed [cpid_pkg::PROD_W-1:0]               prod_next;
  logic [cpid_pkg::ACC_W-1:0]                       lim;
  logic signed [cpid_pkg::PROD_W-1:0]               lim_s;
  logic signed [cpid_pkg::TERM_W-1:0]               term_next;
  logic signed [cpid_pkg::SUM_W-1:0]                isum;
  logic signed [cpid_pkg::ACC_W-1:0]                integ_next;
  logic signed [cpid_pkg::SUM_W-1:0]                addend;
  logic signed [cpid_pkg::SUM_W-1:0]                olim_s;
  logic signed [cpid_pkg::SUM_W-1:0]                sum_clamped;
  logic signed [cpid_pkg::SUM_W-1:0]                sum_rounded;
  logic signed [cpid_pkg::ERR_W:0]                  diff;

  assign s_axis_tready = (state == S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // multiplier: Horner over the gain digits, most significant first
  assign digit = mul_b[cpid_pkg::GAIN_W-1 -: cpid_pkg::DIGIT_W];
  assign pp    = mul_a * $signed({1'b0, digit});
  assign prod_next = (prod <<< cpid_pkg::DIGIT_W)
    + {{(cpid_pkg::PROD_W-cpid_pkg::ACC_W-cpid_pkg::DIGIT_W-1){pp[$high(pp)]}}, pp};

  assign diff = {err[cpid_pkg::ERR_W-1], err} - {prev_err[cpid_pkg::ERR_W-1], prev_err};

  always_comb begin
    case (phase)
      PH_P:    lim = {{(cpid_pkg::ACC_W-cpid_pkg::LIMIT_W){1'b0}}, prop_limit};
      PH_I:    lim = {1'b0, integ_limit, {cpid_pkg::FRAC_W{1'b0}}};
      PH_D:    lim = {{(cpid_pkg::ACC_W-cpid_pkg::LIMIT_W){1'b0}}, deriv_limit};
      default: lim = '0;
    endcase
    lim_s = $signed({{(cpid_pkg::PROD_W-cpid_pkg::ACC_W){1'b0}}, lim});
  end

  // clamp the P, I and D products to the symmetric limit of their term; the integral update passes unclamped
  always_comb begin
    if (phase == PH_INT) begin
      term_next = prod[cpid_pkg::TERM_W-1:0];
    end else if (prod > lim_s) begin
      term_next = lim_s[cpid_pkg::TERM_W-1:0];
    end else if (prod < -lim_s) begin
      term_next = -lim_s[cpid_pkg::TERM_W-1:0];
    end else begin
      term_next = prod[cpid_pkg::TERM_W-1:0];
    end
  end

  // saturating integral update
  always_comb begin
    isum = {{(cpid_pkg::SUM_W-cpid_pkg::ACC_W){integ[cpid_pkg::ACC_W-1]}}, integ}
         + {term[cpid_pkg::TERM_W-1], term};
    if (isum > cpid_pkg::ACC_MAX_S) begin
      integ_next = cpid_pkg::ACC_MAX_S[cpid_pkg::ACC_W-1:0];
    end else if (isum < cpid_pkg::ACC_MIN_S) begin
      integ_next = cpid_pkg::ACC_MIN_S[cpid_pkg::ACC_W-1:0];
    end else begin
      integ_next = isum[cpid_pkg::ACC_W-1:0];
    end
  end

  // P and D are integers: scale to Q.16; I is already Q.16
  always_comb begin
    if (phase == PH_I) begin
      addend = {term[cpid_pkg::TERM_W-1], term};
    end else begin
      addend = {term[cpid_pkg::SUM_W-cpid_pkg::FRAC_W-1:0], {cpid_pkg::FRAC_W{1'b0}}};
    end
  end

  always_comb begin
    olim_s = $signed({{(cpid_pkg::SUM_W-cpid_pkg::LIMIT_W-cpid_pkg::FRAC_W){1'b0}},
                      output_limit, {cpid_pkg::FRAC_W{1'b0}}});
    if (sum > olim_s) begin
      sum_clamped = olim_s;
    end else if (sum < -olim_s) begin
      sum_clamped = -olim_s;
    end else begin
      sum_clamped = sum;
    end
    sum_rounded = sum + cpid_pkg::ROUND_HALF;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain    <= '0;
      integ_gain   <= '0;
      deriv_gain   <= '0;
      step_period  <= cpid_pkg::STEP_PERIOD_RST;
      prop_limit   <= cpid_pkg::LIMIT_RST;
      integ_limit  <= cpid_pkg::LIMIT_RST;
      deriv_limit  <= cpid_pkg::LIMIT_RST;
      output_limit <= cpid_pkg::LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cpid_pkg::REG_PROP_GAIN:    prop_gain    <= cfg_data[cpid_pkg::GAIN_W-1:0];
        cpid_pkg::REG_INTEG_GAIN:   integ_gain   <= cfg_data[cpid_pkg::GAIN_W-1:0];
        cpid_pkg::REG_DERIV_GAIN:   deriv_gain   <= cfg_data[cpid_pkg::GAIN_W-1:0];
        cpid_pkg::REG_STEP_PERIOD:  step_period  <= cfg_data[cpid_pkg::GAIN_W-1:0];
        cpid_pkg::REG_PROP_LIMIT:   prop_limit   <= cfg_data[cpid_pkg::LIMIT_W-1:0];
        cpid_pkg::REG_INTEG_LIMIT:  integ_limit  <= cfg_data[cpid_pkg::LIMIT_W-1:0];
        cpid_pkg::REG_DERIV_LIMIT:  deriv_limit  <= cfg_data[cpid_pkg::LIMIT_W-1:0];
        cpid_pkg::REG_OUTPUT_LIMIT: output_limit <= cfg_data[cpid_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_INT;
      integ     <= '0;
      prev_err  <= '0;
      have_prev <= 1'b0;
      dcnt      <= '0;
      out_valid <= 1'b0;
    end else begin
      // the output step reloads the register itself when it is taken
      if (out_valid && m_axis_tready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_fire) begin
            if (s_axis_tuser) begin
              integ <= '0;
            end else begin
              err   <= s_axis_tdata;
              phase <= PH_INT;
              sum   <= '0;
              state <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          case (phase)
            PH_INT: begin
              mul_a <= {{(cpid_pkg::ACC_W-cpid_pkg::ERR_W){err[cpid_pkg::ERR_W-1]}}, err};
              mul_b <= step_period;
            end
            PH_P: begin
              mul_a <= {{(cpid_pkg::ACC_W-cpid_pkg::ERR_W){err[cpid_pkg::ERR_W-1]}}, err};
              mul_b <= prop_gain;
            end
            PH_I: begin
              mul_a <= integ;
              mul_b <= integ_gain;
            end
            default: begin
              mul_a <= {{(cpid_pkg::ACC_W-cpid_pkg::ERR_W-1){diff[cpid_pkg::ERR_W]}}, diff};
              mul_b <= deriv_gain;
            end
          endcase
          prod  <= '0;
          dcnt  <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= prod_next;
          mul_b <= {mul_b[cpid_pkg::GAIN_W-cpid_pkg::DIGIT_W-1:0],
                    {cpid_pkg::DIGIT_W{1'b0}}};
          dcnt  <= dcnt + 1'b1;
          if (dcnt == cpid_pkg::CNT_W'(cpid_pkg::DIGITS - 1)) begin
            state <= S_TERM;
          end
        end
        S_TERM: begin
          term  <= term_next;
          state <= S_ACC;
        end
        S_ACC: begin
          case (phase)
            PH_INT: begin
              integ <= integ_next;
              phase <= PH_P;
              state <= S_LOAD;
            end
            PH_P: begin
              sum   <= sum + addend;
              phase <= PH_I;
              state <= S_LOAD;
            end
            PH_I: begin
              sum <= sum + addend;
              // D is zero until a sample has been seen
              if (have_prev) begin
                phase <= PH_D;
                state <= S_LOAD;
              end else begin
                state <= S_ROUND;
              end
            end
            default: begin
              sum   <= sum + addend;
              state <= S_ROUND;
            end
          endcase
        end
        S_ROUND: begin
          sum   <= sum_clamped;
          state <= S_OUT;
        end
        S_OUT: begin
          // hold until the output register is free
          if (!out_valid || m_axis_tready) begin
            out_data  <= sum_rounded[cpid_pkg::FRAC_W+cpid_pkg::OUT_W-1:cpid_pkg::FRAC_W];
            out_valid <= 1'b1;
            prev_err  <= err;
            have_prev <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_clear_zeroes_integral: assert property (@(posedge clk) disable iff (rst)
    (s_fire && s_axis_tuser) |=> (integ == '0))
    else $error("integral not cleared after clear item");

  a_digit_count_idle: assert property (@(posedge clk) disable iff (rst)
    (state != S_MUL) |-> (dcnt == '0))
    else $error("digit counter left running outside multiply");

  a_result_from_output_step: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == S_OUT))
    else $error("result raised outside the output step");

  a_no_result_without_history: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD && phase == PH_D) |-> have_prev)
    else $error("derivative product started before any sample");

endmodule

>>> tb/cpid_tb_pkg.sv
// Operation codes shared by the regulator's stimulus and checker modules.
`timescale 1ns / 1ps

package cpid_tb_pkg;

  // operation field carried on s_axis_tuser
  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_CLEAR  = 1'b1
  } pid_op_t;

endpackage

>>> tb/clamped_pid_controller_checker.sv
// Checker for the clamped PID regulator: mirrors its state and compares each correction.
`timescale 1ns / 1ps

module clamped_pid_controller_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [cpid_pkg::ERR_W-1:0]      s_axis_tdata,
  input  logic                            s_axis_tuser,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [cpid_pkg::OUT_W-1:0]      m_axis_tdata,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  cpid_pkg::cfg_index_t            cfg_index,
  input  logic [cpid_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              failures,
  output int                              outstanding,
  output int                              checked
);

  localparam longint Q16_ONE  = 65536;
  localparam longint Q16_HALF = 32768;
  localparam longint ACC_HI   = (longint'(1) <<< (cpid_pkg::ACC_W - 1)) - 1;
  localparam longint ACC_LO   = -ACC_HI - 1;

  logic [cpid_pkg::GAIN_W-1:0]  prop_gain, integ_gain, deriv_gain, step_period;
  logic [cpid_pkg::LIMIT_W-1:0] prop_limit, integ_limit, deriv_limit, output_limit;

  longint                            integral;
  logic signed [cpid_pkg::ERR_W-1:0] prev_sample;
  bit                                have_last;

  logic [cpid_pkg::OUT_W-1:0] corrections_due[$];
  logic [cpid_pkg::OUT_W-1:0] want;
  int                         mismatches;
  int                         compared;

  function automatic longint clamp_sym(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Advance the integral and previous error, and return the rounded correction.
  function automatic logic [cpid_pkg::OUT_W-1:0] next_correction(
    logic signed [cpid_pkg::ERR_W-1:0] err
  );
    longint e, p, i, d, sum, rounded;
    e = longint'(err);
    integral = integral + e * longint'(step_period);
    if (integral > ACC_HI) integral = ACC_HI;
    if (integral < ACC_LO) integral = ACC_LO;
    p = clamp_sym(e * longint'(prop_gain), longint'(prop_limit));
    i = clamp_sym(integral * longint'(integ_gain), longint'(integ_limit) * Q16_ONE);
    if (have_last)
      d = clamp_sym((e - longint'(prev_sample)) * longint'(deriv_gain),
                    longint'(deriv_limit));
    else
      d = 0;
    sum = clamp_sym(p * Q16_ONE + i + d * Q16_ONE, longint'(output_limit) * Q16_ONE);
    // halves round towards plus infinity
    rounded = (sum + Q16_HALF) >>> cpid_pkg::FRAC_W;
    prev_sample = err;
    have_last = 1'b1;
    return rounded[cpid_pkg::OUT_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      prop_gain    = '0;
      integ_gain   = '0;
      deriv_gain   = '0;
      step_period  = cpid_pkg::STEP_PERIOD_RST;
      prop_limit   = cpid_pkg::LIMIT_RST;
      integ_limit  = cpid_pkg::LIMIT_RST;
      deriv_limit  = cpid_pkg::LIMIT_RST;
      output_limit = cpid_pkg::LIMIT_RST;
      integral     = 0;
      prev_sample  = '0;
      have_last    = 1'b0;
      corrections_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          cpid_pkg::REG_PROP_GAIN:    prop_gain    = cfg_data[cpid_pkg::GAIN_W-1:0];
          cpid_pkg::REG_INTEG_GAIN:   integ_gain   = cfg_data[cpid_pkg::GAIN_W-1:0];
          cpid_pkg::REG_DERIV_GAIN:   deriv_gain   = cfg_data[cpid_pkg::GAIN_W-1:0];
          cpid_pkg::REG_STEP_PERIOD:  step_period  = cfg_data[cpid_pkg::GAIN_W-1:0];
          cpid_pkg::REG_PROP_LIMIT:   prop_limit   = cfg_data[cpid_pkg::LIMIT_W-1:0];
          cpid_pkg::REG_INTEG_LIMIT:  integ_limit  = cfg_data[cpid_pkg::LIMIT_W-1:0];
          cpid_pkg::REG_DERIV_LIMIT:  deriv_limit  = cfg_data[cpid_pkg::LIMIT_W-1:0];
          cpid_pkg::REG_OUTPUT_LIMIT: output_limit = cfg_data[cpid_pkg::LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == cpid_tb_pkg::OP_CLEAR)
          integral = 0;
        else
          corrections_due.push_back(next_correction(s_axis_tdata));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (corrections_due.size() == 0) begin
          $error("correction: expected none, got %0d", $signed(m_axis_tdata));
          mismatches++;
        end else begin
          want = corrections_due.pop_front();
          compared++;
          if (m_axis_tdata !== want) begin
            $error("correction: expected %0d, got %0d", $signed(want),
                   $signed(m_axis_tdata));
            mismatches++;
          end
        end
      end
    end
    failures    <= mismatches;
    outstanding <= corrections_due.size();
    checked     <= compared;
  end

endmodule

>>> tb/clamped_pid_controller_top_test.sv
// Stimulus and verdict for the clamped PID regulator, with its checker beside it.
`timescale 1ns / 1ps

module clamped_pid_controller_top_test;

  logic                            clk           = 1'b0;
  logic                            rst           = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [cpid_pkg::ERR_W-1:0]      s_axis_tdata  = '0;  // [15:0] error_sample
  logic                            s_axis_tuser  = 1'b0;  // [0] operation
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [cpid_pkg::OUT_W-1:0]      m_axis_tdata;  // [31:0] correction
  logic                            cfg_valid     = 1'b0;
  logic                            cfg_ready;
  cpid_pkg::cfg_index_t            cfg_index     = '0;
  logic [cpid_pkg::CFG_DATA_W-1:0] cfg_data      = '0;

  int failures, outstanding, checked;

  bit   calm;
  int   ready_hold;
  int   items_sent, clears_sent, settings_used;
  logic [cpid_pkg::CFG_DATA_W-1:0] reg_vals [8];

  always #5 clk = ~clk;

  clamped_pid_controller_top DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  clamped_pid_controller_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .failures      (failures),
    .outstanding   (outstanding),
    .checked       (checked)
  );

  // Receiver pacing: mostly short stalls, now and then a long one.
  always @(posedge clk) begin : rx_pace
    int roll;
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (calm) begin
      m_axis_tready <= 1'b1;
    end else begin
      roll = $urandom_range(99);
      if (roll < 50) begin
        m_axis_tready <= 1'b1;
        ready_hold    <= $urandom_range(12);
      end else if (roll < 92) begin
        m_axis_tready <= 1'b0;
        ready_hold    <= $urandom_range(3);
      end else begin
        m_axis_tready <= 1'b0;
        ready_hold    <= $urandom_range(60, 15);
      end
    end
  end

  function automatic int idle_gap();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(60, 15);
  endfunction

  function automatic logic [cpid_pkg::ERR_W-1:0] pick_error();
    int unsigned r;
    case ($urandom_range(7))
      0:       r = 32'h7FFF;
      1:       r = 32'h8000;
      2, 3:    r = $urandom_range(64) - 32;
      default: r = $urandom();
    endcase
    return r[cpid_pkg::ERR_W-1:0];
  endfunction

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(5))
      0:       return 32'd0;
      1:       return 32'hFFFF;
      2:       return $urandom_range(16, 1);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_period();
    case ($urandom_range(5))
      0:       return 32'd0;
      1:       return 32'd1;
      2:       return 32'hFFFF;
      default: return $urandom();
    endcase
  endfunction

  // Upper bits beyond the register width are deliberately left random.
  function automatic logic [31:0] pick_limit();
    case ($urandom_range(5))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom_range(5000);
      default: return $urandom();
    endcase
  endfunction

  // Hold valid high between back-to-back items; drop it only for a gap.
  task automatic send_item(cpid_tb_pkg::pid_op_t op, logic [cpid_pkg::ERR_W-1:0] err);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= err;
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    if (op == cpid_tb_pkg::OP_CLEAR) clears_sent++;
  endtask

  // Wait for every correction, then past the longest sample and any clear in flight.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_regs(input logic [31:0] pg, ig, dg, per, pl, il, dl, ol);
    reg_vals[cpid_pkg::REG_PROP_GAIN]    = pg;
    reg_vals[cpid_pkg::REG_INTEG_GAIN]   = ig;
    reg_vals[cpid_pkg::REG_DERIV_GAIN]   = dg;
    reg_vals[cpid_pkg::REG_STEP_PERIOD]  = per;
    reg_vals[cpid_pkg::REG_PROP_LIMIT]   = pl;
    reg_vals[cpid_pkg::REG_INTEG_LIMIT]  = il;
    reg_vals[cpid_pkg::REG_DERIV_LIMIT]  = dl;
    reg_vals[cpid_pkg::REG_OUTPUT_LIMIT] = ol;
    settle();
    foreach (reg_vals[idx]) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[cpid_pkg::CFG_IDX_W-1:0];
      cfg_data  <= reg_vals[idx];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset settings: zero gains, first sample has no derivative
    send_item(cpid_tb_pkg::OP_SAMPLE, 16'h7FFF);
    send_item(cpid_tb_pkg::OP_SAMPLE, 16'h8000);
    send_item(cpid_tb_pkg::OP_CLEAR, 16'h5A5A);

    // moderate gains, full limits, swing across the whole error range
    set_regs(3, 2, 5, 32'h4000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
             32'hFFFF_FFFF);
    send_item(cpid_tb_pkg::OP_SAMPLE, 16'h8000);
    send_item(cpid_tb_pkg::OP_SAMPLE, 16'h7FFF);
    send_item(cpid_tb_pkg::OP_SAMPLE, 16'h0000);
    send_item(cpid_tb_pkg::OP_CLEAR, 16'hA5A5);
    send_item(cpid_tb_pkg::OP_SAMPLE, 16'h0001);
    send_item(cpid_tb_pkg::OP_SAMPLE, 16'hFFFF);
    send_item(cpid_tb_pkg::OP_SAMPLE, 16'h7FFF);

    // half-step integral: exact halves round upwards
    set_regs(0, 1, 0, 32'h8000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
             32'hFFFF_FFFF);
    send_item(cpid_tb_pkg::OP_CLEAR, 16'h0000);
    send_item(cpid_tb_pkg::OP_SAMPLE, 16'h0001);
    send_item(cpid_tb_pkg::OP_CLEAR, 16'h0000);
    send_item(cpid_tb_pkg::OP_SAMPLE, 16'hFFFF);
    send_item(cpid_tb_pkg::OP_SAMPLE, 16'hFFFF);

    // zero period freezes the integral
    set_regs(0, 1, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(cpid_tb_pkg::OP_SAMPLE, 16'd100);
    send_item(cpid_tb_pkg::OP_SAMPLE, 16'hFFFB);

    // zero limits force every term to zero
    set_regs(32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF, 0, 0, 0, 0);
    send_item(cpid_tb_pkg::OP_SAMPLE, 16'h7FFF);
    send_item(cpid_tb_pkg::OP_SAMPLE, 16'h8000);

    // largest gains and period, with the largest limits
    set_regs(32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(cpid_tb_pkg::OP_SAMPLE, 16'h7FFF);
    send_item(cpid_tb_pkg::OP_SAMPLE, 16'h7FFF);
    send_item(cpid_tb_pkg::OP_SAMPLE, 16'h8000);
    send_item(cpid_tb_pkg::OP_SAMPLE, 16'h8000);

    // small limits on each term and on the sum
    set_regs(7, 3, 11, 32'h1234, 100, 50, 70, 150);
    send_item(cpid_tb_pkg::OP_SAMPLE, 16'd1000);
    send_item(cpid_tb_pkg::OP_SAMPLE, 16'hFC18);

    for (int ph = 0; ph < 11; ph++) begin
      calm = ($urandom_range(3) == 0);
      set_regs(pick_gain(), pick_gain(), pick_gain(), pick_period(),
               pick_limit(), pick_limit(), pick_limit(), pick_limit());
      repeat (57) begin
        if ($urandom_range(9) == 0)
          send_item(cpid_tb_pkg::OP_CLEAR, pick_error());
        else
          send_item(cpid_tb_pkg::OP_SAMPLE, pick_error());
      end
    end

    settle();
    $display("Drove %0d items (%0d integral clears) through %0d register settings,",
             items_sent, clears_sent, settings_used);
    $display("and compared %0d corrections against the mirrored regulator.", checked);
    if (failures == 0) begin
      $display("clamped_pid_controller_top regression: pass");
    end else begin
      $display("clamped_pid_controller_top regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("clamped_pid_controller_top regression: fail");
    $finish;
  end

endmodule

>>> filelist.f
hdl/cpid_pkg.sv
hdl/clamped_pid_controller_top.sv
tb/cpid_tb_pkg.sv
tb/clamped_pid_controller_checker.sv
tb/clamped_pid_controller_top_test.sv
